// ----- rtl/i2c_register_master_assert.svh -----
// Assertion macros for the register master
`ifndef I2C_REGISTER_MASTER_ASSERT_SVH
`define I2C_REGISTER_MASTER_ASSERT_SVH
// implication checked on every edge outside reset
`define I2CM_ASSERT_IMP(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define I2CM_ASSERT_NXT(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C register master.
// ----------------------------------------------------------------------------
`default_nettype none
package i2cm_pkg;
  localparam logic [1:0] ModeWrite = 2'd0;
  localparam logic [1:0] ModeRead  = 2'd1;
  localparam logic [1:0] ModeBurst = 2'd2;
  localparam logic [1:0] ModeNone  = 2'd3;
  localparam logic [7:0] DevAddrReset = 8'd166;
  localparam logic [0:0] RegDevAddr = 1'b0;

  // input tick item
  typedef struct packed {
    logic       request;
    logic [1:0] mode;
    logic [7:0] reg_addr;
    logic [7:0] write_byte;
    logic       sda_sample;
  } tick_t;

  // result item
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       ack_missing;
  } res_t;
endpackage
`default_nettype wire

// ----- rtl/i2cm_tick_if.sv -----
// ----------------------------------------------------------------------------
// i2cm_tick_if / i2cm_res_if
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface i2cm_tick_if;
  logic            valid;
  logic            ready;
  i2cm_pkg::tick_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cm_res_if;
  logic           valid;
  logic           ready;
  i2cm_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/i2cm_queue.sv -----
// ----------------------------------------------------------------------------
// i2cm_queue
// Two-entry queue between the front and the bus sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module i2cm_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  wire i2cm_pkg::tick_t in_data_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output i2cm_pkg::tick_t out_data_o
);
  i2cm_pkg::tick_t mem_q [2];
  logic rd_q, rd_d, wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // pointers and fill count
  always_comb begin
    rd_d  = pop ? ~rd_q : rd_q;
    wr_d  = push ? ~wr_q : wr_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      rd_q <= rd_d; wr_q <= wr_d; cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end
endmodule
`default_nettype wire

// ----- rtl/i2cm_seq.sv -----
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: one tick per transfer, drives SCL/SDA and collects bytes.
// ----------------------------------------------------------------------------
`default_nettype none
module i2cm_seq #(
  parameter int unsigned HalfPeriod = 5,
  parameter int unsigned BurstLen   = 6
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire [7:0]       dev_addr_i,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  wire i2cm_pkg::tick_t in_data_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output i2cm_pkg::res_t  out_data_o
);
  typedef enum logic [12:0] {
    PhIdle    = 13'b0000000000001,
    PhStartHi = 13'b0000000000010,
    PhStartLo = 13'b0000000000100,
    PhTxHi    = 13'b0000000001000,
    PhTxLo    = 13'b0000000010000,
    PhTxAckHi = 13'b0000000100000,
    PhTxAckLo = 13'b0000001000000,
    PhRxHi    = 13'b0000010000000,
    PhRxLo    = 13'b0000100000000,
    PhMAckHi  = 13'b0001000000000,
    PhMAckLo  = 13'b0010000000000,
    PhStopLo  = 13'b0100000000000,
    PhStopHi  = 13'b1000000000000
  } phase_e;

  localparam logic [3:0] SegLast = 4'(HalfPeriod - 1);
  localparam logic [2:0] BurstLast = 3'(BurstLen - 1);

  phase_e ph_q, ph_d;
  logic [3:0] tmr_q, tmr_d;
  logic [2:0] bit_q, bit_d, byt_q, byt_d;
  logic [7:0] sh_q, sh_d, reg_q, reg_d, dat_q, dat_d;
  logic [1:0] mode_q, mode_d;
  logic nack_q, nack_d;
  logic ov_q;
  i2cm_pkg::res_t od_q, res;
  logic step, seg_end, last_rd;
  logic [2:0] nb;

  // output register; accept a tick when it is free or being drained
  assign in_ready_o  = !ov_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  assign seg_end = (tmr_q >= SegLast);
  assign last_rd = (mode_q == i2cm_pkg::ModeRead) ? 1'b1 : (byt_q >= BurstLast);
  assign nb = byt_q + 3'd1;

  // result of this tick from the current state
  always_comb begin
    res = '0;
    res.scl_level = 1'b1; res.sda_level = 1'b1;
    res.sda_drive = 1'b1; res.busy_res = 1'b1;
    case (ph_q)
      PhIdle:    res.busy_res = 1'b0;
      PhStartHi: ;
      PhStartLo: res.sda_level = 1'b0;
      PhTxHi:    res.sda_level = sh_q[7];
      PhTxLo:    begin res.scl_level = 1'b0; res.sda_level = sh_q[7]; end
      PhTxAckHi: res.sda_drive = 1'b0;
      PhTxAckLo: begin res.scl_level = 1'b0; res.sda_drive = 1'b0; end
      PhRxHi:    res.sda_drive = 1'b0;
      PhRxLo: begin
        res.scl_level = 1'b0; res.sda_drive = 1'b0;
        if (seg_end && bit_q == 3'd7) begin
          res.read_valid = 1'b1; res.read_byte = sh_q; res.read_last = last_rd;
        end
      end
      PhMAckHi:  res.sda_level = last_rd;
      PhMAckLo:  begin res.scl_level = 1'b0; res.sda_level = last_rd; end
      PhStopLo:  res.sda_level = 1'b0;
      PhStopHi:  res.ack_missing = seg_end & nack_q;
      default:   res.busy_res = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    ph_d = ph_q; tmr_d = tmr_q; bit_d = bit_q; byt_d = byt_q; sh_d = sh_q;
    reg_d = reg_q; dat_d = dat_q; mode_d = mode_q; nack_d = nack_q;
    if (ph_q == PhIdle) begin
      if (in_data_i.request && in_data_i.mode != i2cm_pkg::ModeNone) begin
        mode_d = in_data_i.mode; reg_d = in_data_i.reg_addr;
        dat_d = in_data_i.write_byte; nack_d = 1'b0;
        tmr_d = '0; bit_d = '0; byt_d = '0; sh_d = '0; ph_d = PhStartHi;
      end
    end else if (!seg_end) begin
      tmr_d = tmr_q + 4'd1;
    end else begin
      tmr_d = '0;
      case (ph_q)
        PhStartHi: ph_d = PhStartLo;
        PhStartLo: begin
          sh_d = (byt_q == 3'd0) ? dev_addr_i : dev_addr_i + 8'd1;
          bit_d = '0; ph_d = PhTxHi;
        end
        PhTxHi: ph_d = PhTxLo;
        PhTxLo: begin
          if (bit_q == 3'd7) begin bit_d = '0; ph_d = PhTxAckHi; end
          else begin sh_d = {sh_q[6:0], 1'b0}; bit_d = bit_q + 3'd1; ph_d = PhTxHi; end
        end
        PhTxAckHi: begin
          if (in_data_i.sda_sample) nack_d = 1'b1;
          ph_d = PhTxAckLo;
        end
        PhTxAckLo: begin
          byt_d = nb;
          if (nb == 3'd1) begin sh_d = reg_q; bit_d = '0; ph_d = PhTxHi; end
          else if (mode_q == i2cm_pkg::ModeWrite) begin
            if (nb == 3'd2) begin sh_d = dat_q; bit_d = '0; ph_d = PhTxHi; end
            else ph_d = PhStopLo;
          end else if (nb == 3'd2) ph_d = PhStartHi;
          else begin byt_d = '0; bit_d = '0; sh_d = '0; ph_d = PhRxHi; end
        end
        PhRxHi: begin sh_d = {sh_q[6:0], in_data_i.sda_sample}; ph_d = PhRxLo; end
        PhRxLo: begin
          if (bit_q == 3'd7) begin bit_d = '0; ph_d = PhMAckHi; end
          else begin bit_d = bit_q + 3'd1; ph_d = PhRxHi; end
        end
        PhMAckHi: ph_d = PhMAckLo;
        PhMAckLo: begin
          if (last_rd) ph_d = PhStopLo;
          else begin byt_d = nb; sh_d = '0; ph_d = PhRxHi; end
        end
        PhStopLo: ph_d = PhStopHi;
        default: begin
          ph_d = PhIdle; bit_d = '0; byt_d = '0; sh_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle; tmr_q <= '0; bit_q <= '0; byt_q <= '0; sh_q <= '0;
      reg_q <= '0; dat_q <= '0; mode_q <= '0; nack_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (step) begin
        ph_q <= ph_d; tmr_q <= tmr_d; bit_q <= bit_d; byt_q <= byt_d;
        sh_q <= sh_d; reg_q <= reg_d; dat_q <= dat_d; mode_q <= mode_d;
        nack_q <= nack_d;
      end
      if (step) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) od_q <= res;
  end
endmodule
`default_nettype wire

// ----- rtl/i2c_register_master.sv -----
// ----------------------------------------------------------------------------
// i2c_register_master
// I2C master for register write, read and burst read, one tick per transfer.
// ----------------------------------------------------------------------------
// Use: every transfer on tick_in is one bus time tick carrying a request,
// mode, register address, write byte and the sampled SDA level. Each tick
// yields exactly one transfer on res_out with SCL/SDA levels, busy and any
// received byte. A front queue of two entries takes ticks; the sequencer
// consumes one per cycle and puts its result in an output register, so the
// sustained rate is one tick per clock while res_out is ready. A tick is held
// in the queue, then stepped by the sequencer, and its result is held in the
// output register until res_out takes it. When res_out stalls, the output
// register holds, the sequencer stops and the queue fills, then tick_in ready
// drops. Reset clears the sequencer to idle, the queue to empty and the
// device address register to 166. The address register is written over the
// APB port at byte address 0; the user must write it only while the block is
// idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none
`include "i2c_register_master_assert.svh"
module i2c_register_master #(
  parameter int unsigned HalfPeriod = 5,
  parameter int unsigned BurstLen   = 6
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  i2cm_tick_if.sink   tick_in,
  i2cm_res_if.source  res_out,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [1:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [1:0] DevAddrOffs = 2'(4 * i2cm_pkg::RegDevAddr);

  logic [7:0] dev_q, dev_d;
  logic q_valid, q_ready;
  i2cm_pkg::tick_t q_data;
  logic wr_en;

  // configuration register
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign dev_d  = (wr_en && paddr == DevAddrOffs) ? pwdata[7:0] : dev_q;
  assign prdata = (paddr == DevAddrOffs) ? {24'd0, dev_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dev_q <= i2cm_pkg::DevAddrReset;
    else dev_q <= dev_d;
  end

  i2cm_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(tick_in.valid), .in_ready_o(tick_in.ready), .in_data_i(tick_in.data),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_data)
  );

  i2cm_seq #(.HalfPeriod(HalfPeriod), .BurstLen(BurstLen)) u_seq (
    .clk_i, .rst_ni, .dev_addr_i(dev_q),
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_data_i(q_data),
    .out_valid_o(res_out.valid), .out_ready_i(res_out.ready), .out_data_o(res_out.data)
  );

  // checks
  `I2CM_ASSERT_IMP(a_rv_busy, clk_i, rst_ni, res_out.valid && res_out.data.read_valid,
                   res_out.data.busy_res && !res_out.data.sda_drive)
  `I2CM_ASSERT_IMP(a_miss_busy, clk_i, rst_ni, res_out.valid && res_out.data.ack_missing,
                   res_out.data.busy_res && res_out.data.scl_level)
  `I2CM_ASSERT_NXT(a_hold, clk_i, rst_ni, res_out.valid && !res_out.ready,
                   res_out.valid && $stable(res_out.data))
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C register master. Each bus tick is sent as a
// transfer and scored against an in-bench model of the bus sequencer; every
// result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  localparam int unsigned HalfTicks  = 5;
  localparam int unsigned BurstBytes = 6;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemTarget = 1650;

  typedef enum logic [4:0] {
    PhIdle, PhStartHi, PhStartLo, PhTxHi, PhTxLo, PhTxAckHi, PhTxAckLo,
    PhRxHi, PhRxLo, PhMackHi, PhMackLo, PhStopLo, PhStopHi
  } bus_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  i2cm_tick_if tick_bus ();
  i2cm_res_if  res_bus ();

  i2c_register_master #(.HalfPeriod(HalfTicks), .BurstLen(BurstBytes)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .tick_in(tick_bus), .res_out(res_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // sequencer model state
  bus_phase_e ph;
  logic [3:0] tmr;
  logic [2:0] bit_idx, byte_idx;
  logic [7:0] shreg, dev_addr, hold_reg, hold_data;
  logic [1:0] hold_mode;
  logic nak_flag;

  i2cm_pkg::res_t bus_results_q[$];
  int   mismatches = 0;
  int   ticks_sent = 0;
  int unsigned cycles = 0;
  bit   steady = 1'b0;

  function automatic bit last_rx_byte();
    int count;
    count = (hold_mode == i2cm_pkg::ModeRead) ? 1 : BurstBytes;
    return (int'(byte_idx) + 1 >= count);
  endfunction

  function automatic void load_byte(logic [7:0] v);
    shreg = v; bit_idx = '0; ph = PhTxHi;
  endfunction

  function automatic void go_idle();
    ph = PhIdle; tmr = '0; bit_idx = '0; byte_idx = '0; shreg = '0;
  endfunction

  // move to the next bus segment
  function automatic void next_segment(logic sda);
    case (ph)
      PhStartHi: ph = PhStartLo;
      PhStartLo: load_byte(byte_idx == 0 ? dev_addr : dev_addr + 8'd1);
      PhTxHi: ph = PhTxLo;
      PhTxLo: begin
        if (bit_idx == 3'd7) begin
          bit_idx = '0; ph = PhTxAckHi;
        end else begin
          shreg = shreg << 1; bit_idx++; ph = PhTxHi;
        end
      end
      PhTxAckHi: begin
        if (sda) nak_flag = 1'b1;
        ph = PhTxAckLo;
      end
      PhTxAckLo: begin
        byte_idx++;
        if (byte_idx == 3'd1) load_byte(hold_reg);
        else if (hold_mode == i2cm_pkg::ModeWrite) begin
          if (byte_idx == 3'd2) load_byte(hold_data);
          else ph = PhStopLo;
        end else if (byte_idx == 3'd2) ph = PhStartHi;
        else begin
          byte_idx = '0; bit_idx = '0; shreg = '0; ph = PhRxHi;
        end
      end
      PhRxHi: begin
        shreg = {shreg[6:0], sda}; ph = PhRxLo;
      end
      PhRxLo: begin
        if (bit_idx == 3'd7) begin
          bit_idx = '0; ph = PhMackHi;
        end else begin
          bit_idx++; ph = PhRxHi;
        end
      end
      PhMackHi: ph = PhMackLo;
      PhMackLo: begin
        if (last_rx_byte()) ph = PhStopLo;
        else begin
          byte_idx++; shreg = '0; ph = PhRxHi;
        end
      end
      PhStopLo: ph = PhStopHi;
      default: go_idle();
    endcase
  endfunction

  // bus outputs for one tick, then advance the model
  function automatic i2cm_pkg::res_t predict_tick(i2cm_pkg::tick_t t);
    i2cm_pkg::res_t r;
    bit seg_end;
    seg_end = (int'(tmr) + 1 >= HalfTicks);
    r = '0;
    r.scl_level = 1'b1; r.sda_level = 1'b1; r.sda_drive = 1'b1; r.busy_res = 1'b1;
    case (ph)
      PhIdle: r.busy_res = 1'b0;
      PhStartHi: ;
      PhStartLo: r.sda_level = 1'b0;
      PhTxHi: r.sda_level = shreg[7];
      PhTxLo: begin
        r.scl_level = 1'b0; r.sda_level = shreg[7];
      end
      PhTxAckHi, PhRxHi: r.sda_drive = 1'b0;
      PhTxAckLo: begin
        r.scl_level = 1'b0; r.sda_drive = 1'b0;
      end
      PhRxLo: begin
        r.scl_level = 1'b0; r.sda_drive = 1'b0;
        if (seg_end && bit_idx == 3'd7) begin
          r.read_valid = 1'b1; r.read_byte = shreg; r.read_last = last_rx_byte();
        end
      end
      PhMackHi: r.sda_level = last_rx_byte();
      PhMackLo: begin
        r.scl_level = 1'b0; r.sda_level = last_rx_byte();
      end
      PhStopLo: r.sda_level = 1'b0;
      PhStopHi: if (seg_end) r.ack_missing = nak_flag;
      default: r.busy_res = 1'b0;
    endcase
    if (ph == PhIdle) begin
      if (t.request && t.mode != i2cm_pkg::ModeNone) begin
        hold_mode = t.mode; hold_reg = t.reg_addr; hold_data = t.write_byte;
        nak_flag = 1'b0;
        go_idle();
        ph = PhStartHi;
      end
    end else if (!seg_end) tmr++;
    else begin
      tmr = '0;
      if (ph == PhStopHi) go_idle();
      else next_segment(t.sda_sample);
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    i2cm_pkg::res_t got, want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      got = res_bus.data;
      if (bus_results_q.size() == 0) report_mismatch("unexpected transfer", 1, 0);
      else begin
        want = bus_results_q.pop_front();
        if (got.scl_level !== want.scl_level)
          report_mismatch("scl_level", got.scl_level, want.scl_level);
        if (got.sda_level !== want.sda_level)
          report_mismatch("sda_level", got.sda_level, want.sda_level);
        if (got.sda_drive !== want.sda_drive)
          report_mismatch("sda_drive", got.sda_drive, want.sda_drive);
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", got.busy_res, want.busy_res);
        if (got.read_byte !== want.read_byte)
          report_mismatch("read_byte", got.read_byte, want.read_byte);
        if (got.read_valid !== want.read_valid)
          report_mismatch("read_valid", got.read_valid, want.read_valid);
        if (got.read_last !== want.read_last)
          report_mismatch("read_last", got.read_last, want.read_last);
        if (got.ack_missing !== want.ack_missing)
          report_mismatch("ack_missing", got.ack_missing, want.ack_missing);
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i)
    res_bus.ready <= steady || ($urandom_range(99) >= 11);

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one tick transfer; valid drops right after the accepting edge
  task automatic send_tick(i2cm_pkg::tick_t t);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 11) begin
      tick_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    tick_bus.valid <= 1'b1;
    tick_bus.data  <= t;
    @(posedge clk_i);
    while (!tick_bus.ready) @(posedge clk_i);
    tick_bus.valid <= 1'b0;
    bus_results_q.push_back(predict_tick(t));
    ticks_sent++;
  endtask

  // one transaction: request tick, then random ticks until the bus is idle
  task automatic run_xfer(logic [1:0] mode, logic [7:0] rg, logic [7:0] dat,
                          int nak_pct, bit hold_mid = 1'b0);
    i2cm_pkg::tick_t t;
    int n;
    t.request = 1'b1; t.mode = mode; t.reg_addr = rg; t.write_byte = dat;
    t.sda_sample = 1'($urandom_range(1));
    send_tick(t);
    n = 0;
    while (ph != PhIdle) begin
      t = i2cm_pkg::tick_t'(20'($urandom));
      t.sda_sample = ($urandom_range(99) < nak_pct);
      send_tick(t);
      n++;
      if (hold_mid && n == 150) wait (bus_results_q.size() == 0);
    end
  endtask

  task automatic write_dev_addr(logic [7:0] v);
    wait (bus_results_q.size() == 0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 2'(4 * i2cm_pkg::RegDevAddr); pwdata <= {24'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    dev_addr = v;
  endtask

  // idle tick, mode three and a plain write with acked and unacked bytes
  task automatic test_write();
    i2cm_pkg::tick_t t;
    t = '0;
    send_tick(t);
    t.request = 1'b1; t.mode = i2cm_pkg::ModeNone; t.reg_addr = 8'hFF;
    t.write_byte = 8'hFF;
    send_tick(t);
    run_xfer(i2cm_pkg::ModeWrite, 8'hA5, 8'h5A, 30);
  endtask

  // single read with device address 254, whose read form 255 is the highest address
  task automatic test_dev_addr();
    write_dev_addr(8'd254);
    run_xfer(i2cm_pkg::ModeRead, 8'h10, 8'h00, 50);
  endtask

  // burst read without idling, with a pause that drains the results midway
  task automatic test_burst();
    steady = 1'b1;
    run_xfer(i2cm_pkg::ModeBurst, 8'h32, 8'h00, 50, 1'b1);
    steady = 1'b0;
  endtask

  // random ticks with the lowest address
  task automatic test_random();
    i2cm_pkg::tick_t t;
    write_dev_addr(8'd0);
    while (ticks_sent < ItemTarget) begin
      t = i2cm_pkg::tick_t'(20'($urandom));
      send_tick(t);
    end
  endtask

  initial begin
    tick_bus.valid = 1'b0;
    tick_bus.data = '0;
    res_bus.ready = 1'b0;
    dev_addr = i2cm_pkg::DevAddrReset;
    go_idle();
    hold_mode = '0; hold_reg = '0; hold_data = '0; nak_flag = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_write();
    test_dev_addr();
    test_burst();
    test_random();
    @(negedge clk_i);
    tick_bus.valid <= 1'b0;
    wait (bus_results_q.size() == 0);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
